// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/mfs_pkg.sv
// Types, codes and helpers shared by the filename sender modules.
`timescale 1ns / 1ps

package mfs_pkg;

   localparam int NAME_LEN   = 11;
   localparam int NAME_IDX_W = $clog2(NAME_LEN);
   localparam int POS_W      = $clog2(NAME_LEN + 1);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_RX    = 2'd2;
   localparam logic [1:0] KIND_TICK  = 2'd3;

   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_EOF = 8'h1A;
   localparam logic [7:0] BYTE_BAD = 8'h75;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NO_RESPONSE = 3'd1;
   localparam logic [2:0] ST_ABORTED     = 3'd2;
   localparam logic [2:0] ST_NAME_FAILED = 3'd3;
   localparam logic [2:0] ST_SUM_FAILED  = 3'd4;

   localparam logic [1:0] REG_ACK_WAIT    = 2'd0;
   localparam logic [1:0] REG_CANCEL_WAIT = 2'd1;
   localparam logic [1:0] REG_SUM_WAIT    = 2'd2;

   localparam logic [3:0] ACK_WAIT_RESET    = 4'd3;
   localparam logic [3:0] CANCEL_WAIT_RESET = 4'd2;
   localparam logic [3:0] SUM_WAIT_RESET    = 4'd10;

   typedef struct packed {
      logic [3:0] ack_wait;
      logic [3:0] cancel_wait;
      logic [3:0] sum_wait;
   } mfs_cfg_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       finished;
      logic [2:0] status;
      logic       last;
   } mfs_result_type;

   // results produced by one item, oldest in r0
   typedef struct packed {
      logic [1:0]     count;
      mfs_result_type r0;
      mfs_result_type r1;
   } mfs_push_type;

   function automatic mfs_result_type mk_result(input logic tx, input logic [7:0] byte_val,
                                                input logic fin, input logic [2:0] st,
                                                input logic lst);
      mfs_result_type r;
      r.tx_valid = tx;
      r.tx_byte  = tx ? byte_val : 8'd0;
      r.finished = fin;
      r.status   = fin ? st : ST_OK;
      r.last     = lst;
      return r;
   endfunction

endpackage

// File: rtl/core/mfs_fsm.sv
// Handshake sequencer: name store, phase, position, timeout and checksum.
`timescale 1ns / 1ps

module mfs_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_accept,
   input  logic [1:0]           kind,
   input  logic [7:0]           name_char,
   input  logic [3:0]           name_index,
   input  logic [7:0]           rx_byte,
   input  mfs_pkg::mfs_cfg_type cfg,
   output mfs_pkg::mfs_push_type push
);
   import mfs_pkg::*;

   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_WAIT_ACK  = 2'd1;
   localparam logic [1:0] PH_WAIT_CAN2 = 2'd2;
   localparam logic [1:0] PH_WAIT_SUM  = 2'd3;

   logic [7:0]       name_ff [NAME_LEN];
   logic [1:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       wt_ff, wt_in;
   logic [7:0]       sum_ff, sum_in;

   logic             name_we;
   logic [POS_W-1:0] pos_inc;
   logic [7:0]       next_char;
   logic [3:0]       wt_inc;
   logic [3:0]       limit;

   assign pos_inc   = pos_ff + POS_W'(1);
   assign next_char = name_ff[pos_inc[NAME_IDX_W-1:0]];
   assign wt_inc    = wt_ff + 4'd1;

   always_comb begin
      case (phase_ff)
         PH_WAIT_ACK:  limit = cfg.ack_wait;
         PH_WAIT_CAN2: limit = cfg.cancel_wait;
         default:      limit = cfg.sum_wait;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      wt_in      = wt_ff;
      sum_in     = sum_ff;
      name_we    = 1'b0;
      push.count = 2'd0;
      push.r0    = mk_result(1'b0, 8'd0, 1'b0, ST_OK, 1'b0);
      push.r1    = mk_result(1'b0, 8'd0, 1'b0, ST_OK, 1'b0);
      if (item_accept) begin
         case (kind)
            KIND_LOAD: begin
               name_we = (phase_ff == PH_IDLE) && (name_index < 4'(NAME_LEN));
            end
            KIND_START: begin
               if (phase_ff == PH_IDLE) begin
                  pos_in     = '0;
                  wt_in      = 4'd0;
                  sum_in     = BYTE_EOF + name_ff[0];
                  phase_in   = PH_WAIT_ACK;
                  push.count = 2'd2;
                  push.r0    = mk_result(1'b1, BYTE_ACK, 1'b0, ST_OK, 1'b0);
                  push.r1    = mk_result(1'b1, name_ff[0], 1'b0, ST_OK, 1'b1);
               end
            end
            KIND_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (wt_inc >= limit) begin
                     phase_in   = PH_IDLE;
                     wt_in      = 4'd0;
                     push.count = 2'd1;
                     case (phase_ff)
                        PH_WAIT_ACK:
                           push.r0 = mk_result(1'b0, 8'd0, 1'b1, ST_NO_RESPONSE, 1'b1);
                        PH_WAIT_CAN2:
                           push.r0 = mk_result(1'b0, 8'd0, 1'b1, ST_NAME_FAILED, 1'b1);
                        default:
                           push.r0 = mk_result(1'b1, BYTE_BAD, 1'b1, ST_SUM_FAILED, 1'b1);
                     endcase
                  end else begin
                     wt_in = wt_inc;
                  end
               end
            end
            KIND_RX: begin
               case (phase_ff)
                  PH_WAIT_ACK: begin
                     if (rx_byte == BYTE_ACK) begin
                        wt_in      = 4'd0;
                        pos_in     = pos_inc;
                        push.count = 2'd1;
                        if (pos_inc >= POS_W'(NAME_LEN)) begin
                           phase_in = PH_WAIT_SUM;
                           push.r0  = mk_result(1'b1, BYTE_EOF, 1'b0, ST_OK, 1'b1);
                        end else begin
                           sum_in  = sum_ff + next_char;
                           push.r0 = mk_result(1'b1, next_char, 1'b0, ST_OK, 1'b1);
                        end
                     end else if (rx_byte == BYTE_CAN) begin
                        phase_in = PH_WAIT_CAN2;
                        wt_in    = 4'd0;
                     end else begin
                        phase_in   = PH_IDLE;
                        wt_in      = 4'd0;
                        push.count = 2'd1;
                        push.r0    = mk_result(1'b0, 8'd0, 1'b1, ST_NAME_FAILED, 1'b1);
                     end
                  end
                  PH_WAIT_CAN2: begin
                     phase_in   = PH_IDLE;
                     wt_in      = 4'd0;
                     push.count = 2'd1;
                     push.r0    = mk_result(1'b0, 8'd0, 1'b1,
                                            (rx_byte == BYTE_CAN) ? ST_ABORTED
                                                                  : ST_NAME_FAILED, 1'b1);
                  end
                  PH_WAIT_SUM: begin
                     phase_in   = PH_IDLE;
                     wt_in      = 4'd0;
                     push.count = 2'd1;
                     if (rx_byte == sum_ff) begin
                        push.r0 = mk_result(1'b1, BYTE_ACK, 1'b1, ST_OK, 1'b1);
                     end else begin
                        push.r0 = mk_result(1'b1, BYTE_BAD, 1'b1, ST_SUM_FAILED, 1'b1);
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         wt_ff    <= 4'd0;
         sum_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         wt_ff    <= wt_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_ff[name_index[NAME_IDX_W-1:0]] <= name_char;
      end
   end

`include "assert_macros.svh"

   `ASSERT_CLK(a_idle_no_wait, clock, reset,
      (phase_ff == PH_IDLE) |-> (wt_ff == 4'd0), "tick count left over in idle")
   `ASSERT_CLK(a_pos_range, clock, reset,
      pos_ff <= POS_W'(NAME_LEN), "name position past end")
   `ASSERT_CLK(a_idle_holds, clock, reset,
      (phase_ff == PH_IDLE && !(item_accept && kind == KIND_START)) |=> (phase_ff == PH_IDLE),
      "left idle without start")

endmodule

// File: rtl/core/mfs_out_queue.sv
// Small result queue: takes up to two results a cycle, delivers one while out_stall is low.
`timescale 1ns / 1ps

module mfs_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  mfs_pkg::mfs_push_type  push,
   output logic                   full,
   output logic                   out_valid,
   input  logic                   out_stall,
   output mfs_pkg::mfs_result_type out_data
);
   import mfs_pkg::*;

   mfs_result_type    entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;
   logic [QPTR_W-1:0] wr_next;

   assign wr_next   = wr_ff + QPTR_W'(1);
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ff];
   assign pop       = out_valid && !out_stall;
   assign full      = count_ff > QCNT_W'(QDEPTH - 2);

   assign wr_in    = wr_ff + QPTR_W'(push.count);
   assign rd_in    = rd_ff + QPTR_W'(pop);
   assign count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.r1;
      end
   end

`include "assert_macros.svh"

   `ASSERT_CLK(a_no_overflow, clock, reset, count_ff <= QCNT_W'(QDEPTH), "result queue overflow")
   `ASSERT_CLK(a_push_room, clock, reset, (push.count != 2'd0) |-> !full, "results pushed while full")

endmodule

// File: rtl/core/modem7_filename_sender_top.sv
// Top level of the MODEM7 batch filename sender with its register port.
`timescale 1ns / 1ps

// MODEM7 batch filename sender. Load the 11 name characters (kind 0) while
// idle, then start (kind 1); feed received bytes (kind 2) and one-second
// ticks (kind 3). Every item is handled in the cycle it is accepted, so one
// item per cycle is taken unless req_stall is high. Results pass through a
// four-entry queue that also parts the two sides; a start yields two results
// in order, and req_stall rises while the queue holds more than two results.
// Name entries are not cleared by reset: load all of them before a start.
// Timeout registers sit at byte addresses 0, 4 and 8.

module modem7_filename_sender_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_name_char,
   input  logic [3:0]  req_name_index,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_finished,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mfs_pkg::*;

   mfs_cfg_type    cfg_ff, cfg_in;
   mfs_push_type   push;
   mfs_result_type out_data;
   logic           q_full;
   logic           accept;
   logic           csr_write;
   logic [1:0]     reg_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_ACK_WAIT:    cfg_in.ack_wait    = csr_pwdata[3:0];
            REG_CANCEL_WAIT: cfg_in.cancel_wait = csr_pwdata[3:0];
            REG_SUM_WAIT:    cfg_in.sum_wait    = csr_pwdata[3:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_ACK_WAIT:    csr_prdata = {28'd0, cfg_ff.ack_wait};
         REG_CANCEL_WAIT: csr_prdata = {28'd0, cfg_ff.cancel_wait};
         REG_SUM_WAIT:    csr_prdata = {28'd0, cfg_ff.sum_wait};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_wait    <= ACK_WAIT_RESET;
         cfg_ff.cancel_wait <= CANCEL_WAIT_RESET;
         cfg_ff.sum_wait    <= SUM_WAIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   mfs_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .item_accept (accept),
      .kind        (req_kind),
      .name_char   (req_name_char),
      .name_index  (req_name_index),
      .rx_byte     (req_rx_byte),
      .cfg         (cfg_ff),
      .push        (push)
   );

   mfs_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (q_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_tx_valid = out_data.tx_valid;
   assign rsp_tx_byte  = out_data.tx_byte;
   assign rsp_finished = out_data.finished;
   assign rsp_status   = out_data.status;
   assign rsp_last     = out_data.last;

endmodule
